// ===== hdl/stl_pkg.sv =====
`default_nettype none
package stl_pkg;

  localparam int CW = 28;   // CORDIC vector width
  localparam int AW = 34;   // angle accumulator width, 2^32 per turn
  localparam int SW = 30;   // square root working width
  localparam int CFG_IDX_W = 2;
  localparam int SQRT_STEPS = 15;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;

  localparam logic OP_WRITE  = 1'b0;
  localparam logic OP_SAMPLE = 1'b1;

  localparam logic [31:0] ATAN_TURNS [24] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
    32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
  };

  typedef struct packed {
    logic              op;
    logic [15:0]       texel_addr;
    logic [7:0]        texel_red;
    logic [7:0]        texel_green;
    logic [7:0]        texel_blue;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
  } in_word_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } out_word_t;

  typedef struct packed {
    logic                valid;
    logic                op;
    logic [15:0]         addr;
    logic [23:0]         rgb;
    logic signed [CW-1:0] pa;
    logic signed [CW-1:0] pb;
    logic signed [AW-1:0] pacc;
    logic                pzero;
    logic signed [CW-1:0] ta;
    logic signed [CW-1:0] tb;
    logic signed [AW-1:0] tacc;
    logic signed [15:0]  z;
    logic [SW-1:0]       n;
    logic [SW-1:0]       r;
  } pipe_t;

endpackage
`default_nettype wire

// ===== hdl/stl_sqrt_step.sv =====
`default_nettype none
module stl_sqrt_step #(
  parameter int BIT_POS = 28
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire stl_pkg::pipe_t d_i,
  output stl_pkg::pipe_t      q_o
);
  import stl_pkg::*;

  localparam logic [SW-1:0] BIT = SW'(1) << BIT_POS;

  pipe_t q_r, q_nxt;
  logic [SW-1:0] trial;

  always_comb begin
    q_nxt = d_i;
    trial = d_i.r + BIT;
    if (d_i.n >= trial) begin
      q_nxt.n = d_i.n - trial;
      q_nxt.r = (d_i.r >> 1) + BIT;
    end else begin
      q_nxt.r = d_i.r >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;
endmodule
`default_nettype wire

// ===== hdl/stl_cordic_step.sv =====
`default_nettype none
module stl_cordic_step #(
  parameter int STEP = 0
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          en,
  input  wire stl_pkg::pipe_t d_i,
  output stl_pkg::pipe_t      q_o
);
  import stl_pkg::*;

  localparam logic signed [AW-1:0] ATAN = {2'b00, ATAN_TURNS[STEP]};

  pipe_t q_r, q_nxt;

  // phi and theta rotate side by side
  always_comb begin
    q_nxt = d_i;
    if (!d_i.pb[CW-1]) begin
      q_nxt.pa   = d_i.pa + (d_i.pb >>> STEP);
      q_nxt.pb   = d_i.pb - (d_i.pa >>> STEP);
      q_nxt.pacc = d_i.pacc + ATAN;
    end else begin
      q_nxt.pa   = d_i.pa - (d_i.pb >>> STEP);
      q_nxt.pb   = d_i.pb + (d_i.pa >>> STEP);
      q_nxt.pacc = d_i.pacc - ATAN;
    end
    if (!d_i.tb[CW-1]) begin
      q_nxt.ta   = d_i.ta + (d_i.tb >>> STEP);
      q_nxt.tb   = d_i.tb - (d_i.ta >>> STEP);
      q_nxt.tacc = d_i.tacc + ATAN;
    end else begin
      q_nxt.ta   = d_i.ta - (d_i.tb >>> STEP);
      q_nxt.tb   = d_i.tb + (d_i.ta >>> STEP);
      q_nxt.tacc = d_i.tacc - ATAN;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r.valid <= 1'b0;
    end else if (en) begin
      q_r <= q_nxt;
    end
  end

  assign q_o = q_r;
endmodule
`default_nettype wire

// ===== hdl/stl_texel_mem.sv =====
`default_nettype none
module stl_texel_mem (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        en,
  input  wire logic        valid_i,
  input  wire logic        op_i,
  input  wire logic [15:0] addr_i,
  input  wire logic [23:0] rgb_i,
  output logic             valid_o,
  output logic [23:0]      rgb_o
);
  import stl_pkg::*;

  logic [23:0] mem [65536];
  logic [23:0] rd_r;
  logic        valid_r;

  always_ff @(posedge clk) begin
    if (en && valid_i) begin
      if (op_i == OP_WRITE) begin
        mem[addr_i] <= rgb_i;
      end else begin
        rd_r <= mem[addr_i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= valid_i && (op_i == OP_SAMPLE);
    end
  end

  assign valid_o = valid_r;
  assign rgb_o   = rd_r;
endmodule
`default_nettype wire

// ===== hdl/spherical_texel_lookup.sv =====
`default_nettype none
// Equirectangular texture lookup. A write word (op 0) stores an RGB texel at
// texel_addr; a sample word (op 1) maps direction (dir_x, dir_y, dir_z, Q1.14)
// to longitude/latitude through a square root and two CORDIC units and
// returns the texel under it. One word is accepted per cycle while in_stall is
// low; a sample's result passes the 15-stage square root, the CORDIC_STEPS
// rotation stages, the texture coordinate stages and the registered texel
// memory read. Writes travel the same pipe, so every sample sees all writes
// accepted before it. The whole pipe holds while a result waits under
// out_stall.
module spherical_texel_lookup #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CORDIC_STEPS = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire stl_pkg::in_word_t           in_word,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output stl_pkg::out_word_t               out_word,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [stl_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [8:0]                  cfg_data
);
  import stl_pkg::*;

  localparam int WD_W = $clog2(MAX_WIDTH + 1);
  localparam int HT_W = $clog2(MAX_HEIGHT + 1);

  logic [8:0] width_r, height_r;
  logic [WD_W-1:0] wd;
  logic [HT_W-1:0] ht;
  logic en;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  width_r  <= cfg_data;
        REG_IMAGE_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r == 9'd0) wd = WD_W'(1);
    else if (32'(width_r) > MAX_WIDTH) wd = WD_W'(MAX_WIDTH);
    else wd = WD_W'(width_r);
    if (height_r == 9'd0) ht = HT_W'(1);
    else if (32'(height_r) > MAX_HEIGHT) ht = HT_W'(MAX_HEIGHT);
    else ht = HT_W'(height_r);
  end

  logic mem_valid;
  logic [23:0] mem_rgb;

  assign en       = !(mem_valid && out_stall);
  assign in_stall = !en;

  // input register
  logic     s0_valid_r;
  in_word_t s0_word_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (en) begin
      s0_valid_r <= in_valid;
      s0_word_r  <= in_word;
    end
  end

  // clamp z, n = 1 - z^2 in Q2.28
  pipe_t p1_r, p1_nxt;
  logic signed [15:0] zc;
  logic signed [31:0] zsq;

  always_comb begin
    p1_nxt = '0;
    if (s0_word_r.dir_z > 16'sd16384) zc = 16'sd16384;
    else if (s0_word_r.dir_z < -16'sd16384) zc = -16'sd16384;
    else zc = s0_word_r.dir_z;
    zsq = zc * zc;
    p1_nxt.valid = s0_valid_r;
    p1_nxt.op    = s0_word_r.op;
    p1_nxt.addr  = s0_word_r.texel_addr;
    p1_nxt.rgb   = {s0_word_r.texel_red, s0_word_r.texel_green, s0_word_r.texel_blue};
    p1_nxt.pa    = {{(CW-24){s0_word_r.dir_y[15]}}, s0_word_r.dir_y, 8'h00};
    p1_nxt.pb    = {{(CW-24){s0_word_r.dir_x[15]}}, s0_word_r.dir_x, 8'h00};
    p1_nxt.z     = zc;
    p1_nxt.n     = (SW'(1) << 28) - SW'(zsq);
    p1_nxt.r     = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r.valid <= 1'b0;
    end else if (en) begin
      p1_r <= p1_nxt;
    end
  end

  pipe_t sq [SQRT_STEPS+1];
  assign sq[0] = p1_r;

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    stl_sqrt_step #(.BIT_POS(28 - 2*k)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(sq[k]), .q_o(sq[k+1])
    );
  end

  // fold left half-plane for phi, set up theta vector (w, z)
  pipe_t pr_r, pr_nxt;

  always_comb begin
    pr_nxt       = sq[SQRT_STEPS];
    pr_nxt.pzero = (sq[SQRT_STEPS].pa == '0) && (sq[SQRT_STEPS].pb == '0);
    pr_nxt.pacc  = '0;
    if (sq[SQRT_STEPS].pa[CW-1]) begin
      pr_nxt.pacc = sq[SQRT_STEPS].pb[CW-1] ? -(AW'(1) <<< 31) : (AW'(1) <<< 31);
      pr_nxt.pa   = -sq[SQRT_STEPS].pa;
      pr_nxt.pb   = -sq[SQRT_STEPS].pb;
    end
    pr_nxt.ta   = CW'(sq[SQRT_STEPS].r) <<< 8;
    pr_nxt.tb   = {{(CW-24){sq[SQRT_STEPS].z[15]}}, sq[SQRT_STEPS].z, 8'h00};
    pr_nxt.tacc = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_r.valid <= 1'b0;
    end else if (en) begin
      pr_r <= pr_nxt;
    end
  end

  pipe_t cs [CORDIC_STEPS+1];
  assign cs[0] = pr_r;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
    stl_cordic_step #(.STEP(i)) u_step (
      .clk(clk), .rst_n(rst_n), .en(en), .d_i(cs[i]), .q_o(cs[i+1])
    );
  end

  // angles to u, v in unsigned Q1.16, 0 to 1.0
  pipe_t cf;
  assign cf = cs[CORDIC_STEPS];

  logic        f1_valid_r, f1_op_r;
  logic [15:0] f1_addr_r;
  logic [23:0] f1_rgb_r;
  logic [16:0] f1_u_r, f1_v_r, u_nxt, v_nxt;
  logic signed [AW-1:0] pacc_e, prnd, trnd;
  logic signed [17:0]   phi16, theta16;
  logic signed [19:0]   uraw, vraw;

  always_comb begin
    pacc_e  = cf.pzero ? '0 : cf.pacc;
    prnd    = (pacc_e + AW'(32768)) >>> 16;
    trnd    = (cf.tacc + AW'(32768)) >>> 16;
    phi16   = prnd[17:0];
    theta16 = trnd[17:0];
    uraw    = 20'sd32768 - 20'(phi16);
    vraw    = (20'(theta16) + 20'sd16384) <<< 1;
    if (uraw < 0) u_nxt = '0;
    else if (uraw > 20'sd65536) u_nxt = 17'd65536;
    else u_nxt = uraw[16:0];
    if (vraw < 0) v_nxt = '0;
    else if (vraw > 20'sd65536) v_nxt = 17'd65536;
    else v_nxt = vraw[16:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f1_valid_r <= 1'b0;
    end else if (en) begin
      f1_valid_r <= cf.valid;
      f1_op_r    <= cf.op;
      f1_addr_r  <= cf.addr;
      f1_rgb_r   <= cf.rgb;
      f1_u_r     <= u_nxt;
      f1_v_r     <= v_nxt;
    end
  end

  // column and row
  logic            f2_valid_r, f2_op_r;
  logic [15:0]     f2_addr_r;
  logic [23:0]     f2_rgb_r;
  logic [WD_W-1:0] f2_col_r, col_nxt;
  logic [HT_W-1:0] f2_row_r, row_nxt;
  logic [16+WD_W:0] colp;
  logic [16+HT_W:0] rowp, rowp_m1;
  logic [16:0]      vinv;

  always_comb begin
    colp = 17'(f1_u_r) * (17+WD_W)'(wd);
    if (colp[16+WD_W:16] > (WD_W+1)'(wd - WD_W'(1))) col_nxt = wd - WD_W'(1);
    else col_nxt = colp[16 +: WD_W];
    vinv    = 17'd65536 - f1_v_r;
    rowp    = (17+HT_W)'(vinv) * (17+HT_W)'(ht);
    rowp_m1 = rowp - (17+HT_W)'(1);
    if (rowp == '0) row_nxt = '0;
    else if (rowp_m1[16+HT_W:16] > (HT_W+1)'(ht - HT_W'(1))) row_nxt = ht - HT_W'(1);
    else row_nxt = rowp_m1[16 +: HT_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f2_valid_r <= 1'b0;
    end else if (en) begin
      f2_valid_r <= f1_valid_r;
      f2_op_r    <= f1_op_r;
      f2_addr_r  <= f1_addr_r;
      f2_rgb_r   <= f1_rgb_r;
      f2_col_r   <= col_nxt;
      f2_row_r   <= row_nxt;
    end
  end

  // texel address, wraps at 16 bits
  logic        f3_valid_r, f3_op_r;
  logic [15:0] f3_addr_r, addr_nxt;
  logic [23:0] f3_rgb_r;
  logic [WD_W+HT_W:0] lin;

  always_comb begin
    lin = (WD_W+HT_W+1)'(f2_col_r)
        + (WD_W+HT_W+1)'(wd) * (WD_W+HT_W+1)'(f2_row_r);
    addr_nxt = (f2_op_r == OP_SAMPLE) ? 16'(lin) : f2_addr_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f3_valid_r <= 1'b0;
    end else if (en) begin
      f3_valid_r <= f2_valid_r;
      f3_op_r    <= f2_op_r;
      f3_addr_r  <= addr_nxt;
      f3_rgb_r   <= f2_rgb_r;
    end
  end

  stl_texel_mem u_mem (
    .clk(clk), .rst_n(rst_n), .en(en),
    .valid_i(f3_valid_r), .op_i(f3_op_r), .addr_i(f3_addr_r), .rgb_i(f3_rgb_r),
    .valid_o(mem_valid), .rgb_o(mem_rgb)
  );

  assign out_valid = mem_valid;
  assign out_word  = out_word_t'(mem_rgb);
endmodule
`default_nettype wire
